// File: design/plfs_pkg.sv
// Shared constants and register indexes for the point light falloff shader.
// No dependencies; imported by plfs_shade_pipe and point_light_falloff_shader_core.
`default_nettype none
package plfs_pkg;

    // Default geometry
    localparam int COORD_BITS_DEF     = 16;
    localparam int DIST_FRAC_BITS_DEF = 8;

    // Fixed register and channel widths
    localparam int RADIUS_W = 16;
    localparam int COLOR_W  = 8;
    localparam int CFG_W    = 16;
    localparam int CFG_IDX_W = 2;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_RADIUS = 2'd0,
        REG_RED    = 2'd1,
        REG_GREEN  = 2'd2,
        REG_BLUE   = 2'd3
    } cfg_reg_t;

endpackage
`default_nettype wire

// File: design/plfs_sqrt_pipe.sv
// Pipelined integer square root, one result bit per register stage.
// Depends on nothing but the stall enable handed down from the top level.
`default_nettype none
module plfs_sqrt_pipe #(
    parameter int RAD_W = 42
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 adv,
    input  wire logic                 in_valid,
    input  wire logic [RAD_W-1:0]     radicand,
    output logic                      out_valid,
    output logic [RAD_W/2-1:0]        root
);
    localparam int ROOT_W = RAD_W / 2;
    localparam int REM_W  = ROOT_W + 2;

    logic              valid_reg [ROOT_W];
    logic [RAD_W-1:0]  rad_reg   [ROOT_W];
    logic [REM_W-1:0]  rem_reg   [ROOT_W];
    logic [ROOT_W-1:0] root_reg  [ROOT_W];

    for (genvar j = 0; j < ROOT_W; j++) begin : g_stage
        logic              pv;
        logic [RAD_W-1:0]  prad;
        logic [REM_W-1:0]  prem;
        logic [ROOT_W-1:0] proot;
        logic [REM_W-1:0]  rem_sh;
        logic [REM_W-1:0]  trial;
        logic              ge;

        // Pick up the previous stage or the input
        if (j == 0) begin : g_first
            assign pv    = in_valid;
            assign prad  = radicand;
            assign prem  = '0;
            assign proot = '0;
        end else begin : g_next
            assign pv    = valid_reg[j-1];
            assign prad  = rad_reg[j-1];
            assign prem  = rem_reg[j-1];
            assign proot = root_reg[j-1];
        end

        // Bring down two radicand bits and try the next root bit
        assign rem_sh = {prem[REM_W-3:0], prad[RAD_W-1 -: 2]};
        assign trial  = {proot, 2'b01};
        assign ge     = (rem_sh >= trial);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[j] <= 1'b0;
            end
            else if (adv)
            begin
                valid_reg[j] <= pv;
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                rad_reg[j]  <= prad << 2;
                rem_reg[j]  <= ge ? (rem_sh - trial) : rem_sh;
                root_reg[j] <= {proot[ROOT_W-2:0], ge};
            end
        end
    end

    assign out_valid = valid_reg[ROOT_W-1];
    assign root      = root_reg[ROOT_W-1];

endmodule
`default_nettype wire

// File: design/plfs_shade_pipe.sv
// One color channel: falloff check, scale by color, pipelined divide by radius.
// Uses plfs_pkg for the color width; stalls with the top-level enable.
`default_nettype none
module plfs_shade_pipe #(
    parameter int D_W  = 26,
    parameter int RS_W = 24
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        adv,
    input  wire logic                        in_valid,
    input  wire logic [D_W-1:0]              dist_fx,
    input  wire logic [RS_W-1:0]             rs,
    input  wire logic [plfs_pkg::COLOR_W-1:0] color,
    output logic                             out_valid,
    output logic [plfs_pkg::COLOR_W-1:0]     level
);
    import plfs_pkg::*;

    localparam int CMP_W = (D_W > RS_W) ? D_W : RS_W;
    localparam int P_W   = RS_W + COLOR_W;

    logic              ok;
    logic [CMP_W-1:0]  span;

    logic              va_reg;
    logic              ok_a_reg;
    logic [RS_W-1:0]   n_a_reg;
    logic [COLOR_W-1:0] c_a_reg;

    logic              vb_reg;
    logic              ok_b_reg;
    logic [P_W-1:0]    prod_b_reg;

    logic              dv_reg  [COLOR_W];
    logic              dok_reg [COLOR_W];
    logic [P_W-1:0]    rem_reg [COLOR_W];
    logic [COLOR_W-1:0] q_reg  [COLOR_W];

    // Distance inside the radius, and what is left of it
    assign ok   = (CMP_W'(dist_fx) < CMP_W'(rs));
    assign span = CMP_W'(rs) - CMP_W'(dist_fx);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
        end
        else if (adv)
        begin
            va_reg <= in_valid;
            vb_reg <= va_reg;
        end
    end

    // Hold remaining span, then scale by the color
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ok_a_reg   <= ok;
            n_a_reg    <= span[RS_W-1:0];
            c_a_reg    <= color;
            ok_b_reg   <= ok_a_reg;
            prod_b_reg <= P_W'(c_a_reg) * P_W'(n_a_reg);
        end
    end

    // Restoring divide by the scaled radius, one quotient bit per stage
    for (genvar k = 0; k < COLOR_W; k++) begin : g_div
        logic              pv;
        logic              pok;
        logic [P_W-1:0]    prem;
        logic [COLOR_W-1:0] pq;
        logic [P_W-1:0]    trial;
        logic              ge;

        if (k == 0) begin : g_first
            assign pv   = vb_reg;
            assign pok  = ok_b_reg;
            assign prem = prod_b_reg;
            assign pq   = '0;
        end else begin : g_next
            assign pv   = dv_reg[k-1];
            assign pok  = dok_reg[k-1];
            assign prem = rem_reg[k-1];
            assign pq   = q_reg[k-1];
        end

        assign trial = P_W'(rs) << (COLOR_W - 1 - k);
        assign ge    = (prem >= trial);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                dv_reg[k] <= 1'b0;
            end
            else if (adv)
            begin
                dv_reg[k] <= pv;
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                dok_reg[k] <= pok;
                rem_reg[k] <= ge ? (prem - trial) : prem;
                q_reg[k]   <= {pq[COLOR_W-2:0], ge};
            end
        end
    end

    // Drop the channel to zero outside the radius
    assign out_valid = dv_reg[COLOR_W-1];
    assign level     = dok_reg[COLOR_W-1] ? q_reg[COLOR_W-1] : '0;

endmodule
`default_nettype wire

// File: design/point_light_falloff_shader_core.sv
// Point light shader with linear distance falloff. Each transfer carries a
// pixel and a light position; one result transfer returns the light color
// scaled by 1 - d/R, rounded down, with d the distance in fixed point
// (DIST_FRAC_BITS fraction bits) and zero at or beyond the radius R. The block
// takes one item per clock unless a result waits on out_ready. The pipeline has
// three stages for differences, squares and sum, one square root stage per
// distance bit, then falloff, color multiply and an eight-stage divide. The whole
// pipeline halts while a result waits on out_ready. Write registers only while no
// item is in flight.
// Depends on plfs_pkg, plfs_sqrt_pipe and plfs_shade_pipe.
`default_nettype none
module point_light_falloff_shader_core #(
    parameter int COORD_BITS     = plfs_pkg::COORD_BITS_DEF,
    parameter int DIST_FRAC_BITS = plfs_pkg::DIST_FRAC_BITS_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_wr_en,
    input  wire logic [plfs_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [plfs_pkg::CFG_W-1:0]    cfg_wdata,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic signed [COORD_BITS-1:0]  pixel_x,
    input  wire logic signed [COORD_BITS-1:0]  pixel_y,
    input  wire logic signed [COORD_BITS-1:0]  source_x,
    input  wire logic signed [COORD_BITS-1:0]  source_y,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic [plfs_pkg::COLOR_W-1:0]       out_red,
    output logic [plfs_pkg::COLOR_W-1:0]       out_green,
    output logic [plfs_pkg::COLOR_W-1:0]       out_blue
);
    import plfs_pkg::*;

    localparam int DIFF_W = COORD_BITS + 1;
    localparam int SQ_W   = 2 * DIFF_W;
    localparam int SUM_W  = SQ_W + 1;
    localparam int RAD_W  = SUM_W + 2 * DIST_FRAC_BITS + 1;
    localparam int ROOT_W = RAD_W / 2;
    localparam int RS_W   = RADIUS_W + DIST_FRAC_BITS;

    logic               adv;
    logic signed [DIFF_W-1:0] dx;
    logic signed [DIFF_W-1:0] dy;

    logic [RADIUS_W-1:0] light_radius_reg;
    logic [COLOR_W-1:0]  light_red_reg;
    logic [COLOR_W-1:0]  light_green_reg;
    logic [COLOR_W-1:0]  light_blue_reg;

    logic               v1_reg, v2_reg, v3_reg;
    logic [DIFF_W-1:0]  adx_reg, ady_reg;
    logic [SQ_W-1:0]    sqx_reg, sqy_reg;
    logic [RAD_W-1:0]   rad_reg;

    logic               root_valid;
    logic [ROOT_W-1:0]  dist_fx;
    logic [RS_W-1:0]    rs;
    logic               vr, vg, vb;

    // Whole pipeline moves unless a result is stuck at the output
    assign adv      = !out_valid || out_ready;
    assign in_ready = adv;

    // Register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            light_radius_reg <= RADIUS_W'(256);
            light_red_reg    <= '1;
            light_green_reg  <= '1;
            light_blue_reg   <= '1;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_RADIUS: light_radius_reg <= cfg_wdata[RADIUS_W-1:0];
                REG_RED:    light_red_reg    <= cfg_wdata[COLOR_W-1:0];
                REG_GREEN:  light_green_reg  <= cfg_wdata[COLOR_W-1:0];
                REG_BLUE:   light_blue_reg   <= cfg_wdata[COLOR_W-1:0];
                default:    ;
            endcase
        end
    end

    // Coordinate differences
    assign dx = DIFF_W'(pixel_x) - DIFF_W'(source_x);
    assign dy = DIFF_W'(pixel_y) - DIFF_W'(source_y);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    // Absolute differences, squares, then the scaled radicand
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            adx_reg <= dx[DIFF_W-1] ? DIFF_W'(-dx) : DIFF_W'(dx);
            ady_reg <= dy[DIFF_W-1] ? DIFF_W'(-dy) : DIFF_W'(dy);
            sqx_reg <= SQ_W'(adx_reg) * SQ_W'(adx_reg);
            sqy_reg <= SQ_W'(ady_reg) * SQ_W'(ady_reg);
            rad_reg <= (RAD_W'(sqx_reg) + RAD_W'(sqy_reg)) << (2 * DIST_FRAC_BITS);
        end
    end

    plfs_sqrt_pipe #(
        .RAD_W (RAD_W)
    ) u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (v3_reg),
        .radicand  (rad_reg),
        .out_valid (root_valid),
        .root      (dist_fx)
    );

    assign rs = RS_W'(light_radius_reg) << DIST_FRAC_BITS;

    plfs_shade_pipe #(.D_W(ROOT_W), .RS_W(RS_W)) u_red (
        .clk(clk), .rst_n(rst_n), .adv(adv), .in_valid(root_valid), .dist_fx(dist_fx),
        .rs(rs), .color(light_red_reg), .out_valid(vr), .level(out_red)
    );

    plfs_shade_pipe #(.D_W(ROOT_W), .RS_W(RS_W)) u_green (
        .clk(clk), .rst_n(rst_n), .adv(adv), .in_valid(root_valid), .dist_fx(dist_fx),
        .rs(rs), .color(light_green_reg), .out_valid(vg), .level(out_green)
    );

    plfs_shade_pipe #(.D_W(ROOT_W), .RS_W(RS_W)) u_blue (
        .clk(clk), .rst_n(rst_n), .adv(adv), .in_valid(root_valid), .dist_fx(dist_fx),
        .rs(rs), .color(light_blue_reg), .out_valid(vb), .level(out_blue)
    );

    assign out_valid = vr;

    // Channels travel in lockstep
    a_lanes_aligned: assert property (@(posedge clk) disable iff (!rst_n)
        (vr == vg) && (vr == vb))
        else $error("color lanes out of step");

    // Attenuation never brightens a channel
    a_no_gain: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_red <= light_red_reg) && (out_green <= light_green_reg)
                      && (out_blue <= light_blue_reg))
        else $error("channel above light color");

    // Zero radius lights nothing
    a_zero_radius: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (light_radius_reg == '0)) |->
        (out_red == '0) && (out_green == '0) && (out_blue == '0))
        else $error("zero radius gave light");

    // Input only backs up behind a waiting result
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid)
        else $error("input stalled with empty output");

endmodule
`default_nettype wire
